### sv/dual_stick_radial_deadzone_defines.svh
// ----------------------------------------------------------------------------
// Dual stick radial dead zone: assertion macros
// Shared concurrent assertion forms used by the port checker.
// ----------------------------------------------------------------------------
`ifndef DUAL_STICK_RADIAL_DEADZONE_DEFINES_SVH
`define DUAL_STICK_RADIAL_DEADZONE_DEFINES_SVH

// Assertion sampled on the rising clock edge and switched off while in reset.
`define DSRD_ASSERT(lbl, clk_s, rst_s, prop) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) prop) \
        else $error("dsrd assertion failed");

// The same form with a message of the caller's choosing.
`define DSRD_ASSERT_MSG(lbl, clk_s, rst_s, prop, msg) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) prop) \
        else $error(msg);

`endif

### sv/dsrd_pkg.sv
// ----------------------------------------------------------------------------
// Dual stick radial dead zone: package
// Constants, register indexes, stick configuration type and the axis table.
// ----------------------------------------------------------------------------
package dsrd_pkg;

    localparam logic [16:0] ONE_Q16   = 17'h10000;
    localparam logic [15:0] DZ_MAX    = 16'd62259;
    localparam logic [9:0]  CURVE_MIN = 10'd256;
    localparam logic [9:0]  CURVE_MAX = 10'd768;
    localparam logic [6:0]  AXIS_MAX  = 7'd127;

    typedef enum logic [2:0] {
        CFG_ENABLE      = 3'd0,
        CFG_DEAD_ZONE   = 3'd1,
        CFG_MOVE_CURVE  = 3'd2,
        CFG_LOOK_CURVE  = 3'd3,
        CFG_INVERT_LOOK = 3'd4,
        CFG_SOUTHPAW    = 3'd5
    } cfg_idx_t;

    // Per-stick settings, already clamped to their legal ranges.
    typedef struct packed {
        logic [15:0] dz;
        logic [9:0]  curve;
    } stick_cfg_t;

    typedef logic [127:0][15:0] axis_tab_t;

    // Upper half of the axis: c * 32768 / 127 for c = 0..127.
    function automatic axis_tab_t build_axis_tab();
        axis_tab_t t;
        for (int i = 0; i < 128; i++)
        begin
            t[i] = 16'((i * 32768) / 127);
        end
        return t;
    endfunction

    localparam axis_tab_t AXIS_TAB = build_axis_tab();

    // Raw byte to Q1.15; below the centre the scale by 256 is exact.
    function automatic logic signed [16:0] axis_q15(input logic [7:0] raw);
        logic signed [16:0] v;
        if (raw[7])
        begin
            v = $signed({1'b0, AXIS_TAB[raw[6:0]]});
        end
        else
        begin
            v = $signed({2'b11, raw[6:0], 8'h00});
        end
        return v;
    endfunction

endpackage

### sv/dsrd_isqrt.sv
// ----------------------------------------------------------------------------
// Dual stick radial dead zone: pipelined integer square root
// Digit-by-digit root, BPS result bits per register stage, with sideband.
// ----------------------------------------------------------------------------
module dsrd_isqrt #(
    parameter int IW  = 36,
    parameter int BPS = 3,
    parameter int SW  = 1
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               in_valid,
    input  logic [IW-1:0]      in_val,
    input  logic [SW-1:0]      in_side,
    output logic               out_valid,
    output logic [IW/2-1:0]    out_root,
    output logic [SW-1:0]      out_side
);

    localparam int RW = IW / 2;
    localparam int NS = RW / BPS;
    localparam int EW = RW + 2;

    logic          st_v    [NS+1];
    logic [EW-1:0] st_rem  [NS+1];
    logic [RW-1:0] st_root [NS+1];
    logic [IW-1:0] st_dat  [NS+1];
    logic [SW-1:0] st_side [NS+1];

    assign st_v[0]    = in_valid;
    assign st_rem[0]  = '0;
    assign st_root[0] = '0;
    assign st_dat[0]  = in_val;
    assign st_side[0] = in_side;

    for (genvar s = 0; s < NS; s++)
    begin : g_stage
        logic [EW-1:0] rem_next;
        logic [RW-1:0] root_next;
        logic [IW-1:0] dat_next;
        logic [EW-1:0] trial;
        logic          v_reg;
        logic [EW-1:0] rem_reg;
        logic [RW-1:0] root_reg;
        logic [IW-1:0] dat_reg;
        logic [SW-1:0] side_reg;

        always_comb
        begin
            rem_next  = st_rem[s];
            root_next = st_root[s];
            dat_next  = st_dat[s];
            trial     = '0;
            for (int b = 0; b < BPS; b++)
            begin
                rem_next = {rem_next[EW-3:0], dat_next[IW-1:IW-2]};
                dat_next = {dat_next[IW-3:0], 2'b00};
                trial    = {root_next, 2'b01};
                if (rem_next >= trial)
                begin
                    rem_next  = rem_next - trial;
                    root_next = {root_next[RW-2:0], 1'b1};
                end
                else
                begin
                    root_next = {root_next[RW-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg <= 1'b0;
            end
            else if (en)
            begin
                v_reg <= st_v[s];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg  <= rem_next;
                root_reg <= root_next;
                dat_reg  <= dat_next;
                side_reg <= st_side[s];
            end
        end

        assign st_v[s+1]    = v_reg;
        assign st_rem[s+1]  = rem_reg;
        assign st_root[s+1] = root_reg;
        assign st_dat[s+1]  = dat_reg;
        assign st_side[s+1] = side_reg;
    end

    assign out_valid = st_v[NS];
    assign out_root  = st_root[NS];
    assign out_side  = st_side[NS];

endmodule

### sv/dsrd_div.sv
// ----------------------------------------------------------------------------
// Dual stick radial dead zone: pipelined restoring divider
// QW quotient bits, BPS per register stage; the quotient must fit QW bits.
// ----------------------------------------------------------------------------
module dsrd_div #(
    parameter int NW  = 33,
    parameter int DW  = 17,
    parameter int QW  = 18,
    parameter int BPS = 3,
    parameter int SW  = 1
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  logic          in_valid,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    input  logic [SW-1:0] in_side,
    output logic          out_valid,
    output logic [QW-1:0] quo,
    output logic [SW-1:0] out_side
);

    localparam int NS  = QW / BPS;
    localparam int RMW = DW + 1;

    logic           st_v    [NS+1];
    logic [RMW-1:0] st_rem  [NS+1];
    logic [QW-1:0]  st_quo  [NS+1];
    logic [QW-1:0]  st_low  [NS+1];
    logic [DW-1:0]  st_den  [NS+1];
    logic [SW-1:0]  st_side [NS+1];

    assign st_v[0]    = in_valid;
    assign st_rem[0]  = RMW'(num[NW-1:QW]);
    assign st_quo[0]  = '0;
    assign st_low[0]  = num[QW-1:0];
    assign st_den[0]  = den;
    assign st_side[0] = in_side;

    for (genvar s = 0; s < NS; s++)
    begin : g_stage
        logic [RMW-1:0] rem_next;
        logic [QW-1:0]  quo_next;
        logic [QW-1:0]  low_next;
        logic           v_reg;
        logic [RMW-1:0] rem_reg;
        logic [QW-1:0]  quo_reg;
        logic [QW-1:0]  low_reg;
        logic [DW-1:0]  den_reg;
        logic [SW-1:0]  side_reg;

        always_comb
        begin
            rem_next = st_rem[s];
            quo_next = st_quo[s];
            low_next = st_low[s];
            for (int b = 0; b < BPS; b++)
            begin
                rem_next = {rem_next[RMW-2:0], low_next[QW-1]};
                low_next = {low_next[QW-2:0], 1'b0};
                if (rem_next >= {1'b0, st_den[s]})
                begin
                    rem_next = rem_next - {1'b0, st_den[s]};
                    quo_next = {quo_next[QW-2:0], 1'b1};
                end
                else
                begin
                    quo_next = {quo_next[QW-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg <= 1'b0;
            end
            else if (en)
            begin
                v_reg <= st_v[s];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg  <= rem_next;
                quo_reg  <= quo_next;
                low_reg  <= low_next;
                den_reg  <= st_den[s];
                side_reg <= st_side[s];
            end
        end

        assign st_v[s+1]    = v_reg;
        assign st_rem[s+1]  = rem_reg;
        assign st_quo[s+1]  = quo_reg;
        assign st_low[s+1]  = low_reg;
        assign st_den[s+1]  = den_reg;
        assign st_side[s+1] = side_reg;
    end

    assign out_valid = st_v[NS];
    assign quo       = st_quo[NS];
    assign out_side  = st_side[NS];

endmodule

### sv/dsrd_stick.sv
// ----------------------------------------------------------------------------
// Dual stick radial dead zone: one stick
// Length, dead zone rescale, response curve and axis scaling, fully pipelined.
// ----------------------------------------------------------------------------
module dsrd_stick (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 in_valid,
    input  logic [7:0]           raw_x,
    input  logic [7:0]           raw_y,
    input  dsrd_pkg::stick_cfg_t cfg,
    output logic                 out_valid,
    output logic signed [7:0]    out_x,
    output logic signed [7:0]    out_y
);

    import dsrd_pkg::*;

    typedef struct packed {
        logic [16:0]        len;
        logic               zero;
        logic signed [16:0] x;
        logic signed [16:0] y;
        logic [16:0]        adj;
    } carry_t;

    typedef struct packed {
        logic [16:0] r;
        carry_t      c;
    } chain_t;

    typedef struct packed {
        logic sat;
        logic neg;
        logic zero;
    } fin_t;

    // Axis conversion and squares.
    logic               a_valid_reg;
    logic signed [16:0] a_x_reg, a_y_reg;
    logic               b_valid_reg;
    logic signed [16:0] b_x_reg, b_y_reg;
    logic [30:0]        b_xx_reg, b_yy_reg;
    logic signed [33:0] xx_full, yy_full;
    logic               c_valid_reg;
    logic signed [16:0] c_x_reg, c_y_reg;
    logic [31:0]        c_sum_reg;

    assign xx_full = a_x_reg * a_x_reg;
    assign yy_full = a_y_reg * a_y_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            a_valid_reg <= in_valid;
            b_valid_reg <= a_valid_reg;
            c_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_x_reg   <= axis_q15(raw_x);
            a_y_reg   <= axis_q15(raw_y);
            b_x_reg   <= a_x_reg;
            b_y_reg   <= a_y_reg;
            b_xx_reg  <= xx_full[30:0];
            b_yy_reg  <= yy_full[30:0];
            c_x_reg   <= b_x_reg;
            c_y_reg   <= b_y_reg;
            c_sum_reg <= {1'b0, b_xx_reg} + {1'b0, b_yy_reg};
        end
    end

    // Vector length: floor(sqrt(4 * (x*x + y*y))).
    carry_t      len_side_in, len_side_out;
    logic        len_valid;
    logic [17:0] len_root;

    assign len_side_in = '{len: 17'd0, zero: 1'b0, x: c_x_reg, y: c_y_reg, adj: 17'd0};

    dsrd_isqrt #(.IW(36), .BPS(3), .SW($bits(carry_t))) u_len (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (c_valid_reg),
        .in_val   ({2'b00, c_sum_reg, 2'b00}),
        .in_side  (len_side_in),
        .out_valid(len_valid),
        .out_root (len_root),
        .out_side (len_side_out)
    );

    // Dead zone test and the operands of the rescale division.
    logic [16:0] len_w, dz_w, nl_w;
    logic        d_valid_reg;
    carry_t      d_c_reg;
    carry_t      d_c_next;
    logic [16:0] d_num_reg, d_den_reg;

    assign len_w = len_root[16:0];
    assign dz_w  = {1'b0, cfg.dz};
    assign nl_w  = (len_w > ONE_Q16) ? ONE_Q16 : len_w;

    always_comb
    begin
        d_c_next      = len_side_out;
        d_c_next.len  = len_w;
        d_c_next.zero = (len_w == 17'd0) || (len_w <= dz_w);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            d_valid_reg <= len_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d_c_reg   <= d_c_next;
            d_num_reg <= nl_w - dz_w;
            d_den_reg <= ONE_Q16 - dz_w;
        end
    end

    carry_t      adj_side_out;
    logic        adj_valid;
    logic [17:0] adj_quo;

    dsrd_div #(.NW(33), .DW(17), .QW(18), .BPS(3), .SW($bits(carry_t))) u_adj (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (d_valid_reg),
        .num      ({d_num_reg, 16'h0000}),
        .den      (d_den_reg),
        .in_side  (d_c_reg),
        .out_valid(adj_valid),
        .quo      (adj_quo),
        .out_side (adj_side_out)
    );

    // Integer part of the exponent: A, A^2, A^3.
    logic        e_valid_reg;
    carry_t      e_c_reg;
    carry_t      e_c_next;
    logic [16:0] e_r2_reg;
    logic [33:0] sq_a, cube_a;
    logic        f_valid_reg;
    carry_t      f_c_reg;
    logic [16:0] f_r_reg;
    logic [16:0] r_sel;

    assign sq_a   = adj_quo[16:0] * adj_quo[16:0];
    assign cube_a = e_r2_reg * e_c_reg.adj;

    always_comb
    begin
        e_c_next     = adj_side_out;
        e_c_next.adj = adj_quo[16:0];
    end

    always_comb
    begin
        case (cfg.curve[9:8])
            2'd1:    r_sel = e_c_reg.adj;
            2'd2:    r_sel = e_r2_reg;
            default: r_sel = cube_a[32:16];
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            e_valid_reg <= 1'b0;
            f_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            e_valid_reg <= adj_valid;
            f_valid_reg <= e_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            e_c_reg  <= e_c_next;
            e_r2_reg <= sq_a[32:16];
            f_c_reg  <= e_c_reg;
            f_r_reg  <= r_sel;
        end
    end

    // Fractional part: eight chained roots, each followed by an optional product.
    logic        ch_v [9];
    logic [16:0] ch_r [9];
    logic [16:0] ch_s [9];
    carry_t      ch_c [9];

    assign ch_v[0] = f_valid_reg;
    assign ch_r[0] = f_r_reg;
    assign ch_s[0] = f_c_reg.adj;
    assign ch_c[0] = f_c_reg;

    for (genvar i = 0; i < 8; i++)
    begin : g_root
        chain_t      sq_side_in, sq_side_out;
        logic        sq_v;
        logic [17:0] sq_root;
        logic [33:0] prod;
        logic        v_reg;
        logic [16:0] r_reg, s_reg;
        carry_t      c_reg;

        assign sq_side_in = '{r: ch_r[i], c: ch_c[i]};

        dsrd_isqrt #(.IW(36), .BPS(3), .SW($bits(chain_t))) u_root (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (en),
            .in_valid (ch_v[i]),
            .in_val   ({3'b000, ch_s[i], 16'h0000}),
            .in_side  (sq_side_in),
            .out_valid(sq_v),
            .out_root (sq_root),
            .out_side (sq_side_out)
        );

        assign prod = sq_side_out.r * sq_root[16:0];

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg <= 1'b0;
            end
            else if (en)
            begin
                v_reg <= sq_v;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                s_reg <= sq_root[16:0];
                c_reg <= sq_side_out.c;
                r_reg <= cfg.curve[7-i] ? prod[32:16] : sq_side_out.r;
            end
        end

        assign ch_v[i+1] = v_reg;
        assign ch_r[i+1] = r_reg;
        assign ch_s[i+1] = s_reg;
        assign ch_c[i+1] = c_reg;
    end

    // Axis scaling: |a| * A, then * 254 / 65536, then / len.
    carry_t      fc;
    logic [16:0] adj_fin, mag_x, mag_y;
    logic [32:0] px_full, py_full;
    logic        g_valid_reg;
    logic [31:0] g_px_reg, g_py_reg;
    logic [16:0] g_len_reg;
    logic        g_zero_reg, g_negx_reg, g_negy_reg;
    logic        h_valid_reg;
    logic [23:0] h_nx_reg, h_ny_reg;
    logic [16:0] h_len_reg;
    logic        h_zero_reg, h_negx_reg, h_negy_reg;
    logic [39:0] wx, wy;

    assign fc      = ch_c[8];
    assign adj_fin = (cfg.curve == CURVE_MIN || fc.adj == 17'd0) ? fc.adj : ch_r[8];
    assign mag_x   = fc.x[16] ? 17'(-fc.x) : 17'(fc.x);
    assign mag_y   = fc.y[16] ? 17'(-fc.y) : 17'(fc.y);
    assign px_full = mag_x[15:0] * adj_fin;
    assign py_full = mag_y[15:0] * adj_fin;
    assign wx      = {g_px_reg, 8'h00} - {7'd0, g_px_reg, 1'b0};
    assign wy      = {g_py_reg, 8'h00} - {7'd0, g_py_reg, 1'b0};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            g_valid_reg <= 1'b0;
            h_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            g_valid_reg <= ch_v[8];
            h_valid_reg <= g_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            g_px_reg   <= px_full[31:0];
            g_py_reg   <= py_full[31:0];
            g_len_reg  <= fc.len;
            g_zero_reg <= fc.zero;
            g_negx_reg <= fc.x[16];
            g_negy_reg <= fc.y[16];
            h_nx_reg   <= wx[39:16];
            h_ny_reg   <= wy[39:16];
            h_len_reg  <= g_len_reg;
            h_zero_reg <= g_zero_reg;
            h_negx_reg <= g_negx_reg;
            h_negy_reg <= g_negy_reg;
        end
    end

    fin_t       fx_in, fy_in, fx_out, fy_out;
    logic       qx_valid, qy_valid;
    logic [7:0] qx, qy;

    assign fx_in = '{sat: {1'b0, h_nx_reg[23:8]} >= h_len_reg, neg: h_negx_reg,
                     zero: h_zero_reg};
    assign fy_in = '{sat: {1'b0, h_ny_reg[23:8]} >= h_len_reg, neg: h_negy_reg,
                     zero: h_zero_reg};

    dsrd_div #(.NW(24), .DW(17), .QW(8), .BPS(4), .SW($bits(fin_t))) u_qx (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (h_valid_reg),
        .num      (h_nx_reg),
        .den      (h_len_reg),
        .in_side  (fx_in),
        .out_valid(qx_valid),
        .quo      (qx),
        .out_side (fx_out)
    );

    dsrd_div #(.NW(24), .DW(17), .QW(8), .BPS(4), .SW($bits(fin_t))) u_qy (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (h_valid_reg),
        .num      (h_ny_reg),
        .den      (h_len_reg),
        .in_side  (fy_in),
        .out_valid(qy_valid),
        .quo      (qy),
        .out_side (fy_out)
    );

    logic [6:0]        mx, my;
    logic signed [7:0] vx, vy;
    logic              o_valid_reg;
    logic signed [7:0] o_x_reg, o_y_reg;

    assign mx = (fx_out.sat || qx > {1'b0, AXIS_MAX}) ? AXIS_MAX : qx[6:0];
    assign my = (fy_out.sat || qy > {1'b0, AXIS_MAX}) ? AXIS_MAX : qy[6:0];
    assign vx = fx_out.zero ? 8'sd0 : (fx_out.neg ? -$signed({1'b0, mx}) : $signed({1'b0, mx}));
    assign vy = fy_out.zero ? 8'sd0 : (fy_out.neg ? -$signed({1'b0, my}) : $signed({1'b0, my}));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            o_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            o_valid_reg <= qx_valid && qy_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            o_x_reg <= vx;
            o_y_reg <= vy;
        end
    end

    assign out_valid = o_valid_reg;
    assign out_x     = o_x_reg;
    assign out_y     = o_y_reg;

endmodule

### sv/dual_stick_radial_deadzone.sv
// ----------------------------------------------------------------------------
// Dual stick radial dead zone
// Conditions the two analogue sticks of one controller sample per transaction.
// ----------------------------------------------------------------------------
// One transaction on the slave stream carries a raw controller sample and
// produces exactly one transaction on the master stream. The block takes a
// new sample in every cycle in which the output is not stalled; throughput
// is then one sample per clock, set by the fully pipelined datapath of each
// stick, whose longest part is the chain of eight pipelined square-root
// units that evaluate the fractional curve exponent. A stall on the master
// side holds every stage in place, so no sample is lost or repeated.
// Configuration is written through its own channel, which is always ready,
// and must only be changed while no sample is in flight.
module dual_stick_radial_deadzone (
    input  logic        clk,
    input  logic        rst_n,
    // Slave stream: left_x [7:0], left_y [15:8], right_x [23:16], right_y [31:24].
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,
    // Master stream: look_x [7:0], look_y [15:8], move_x [23:16], move_y [31:24].
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,
    // Configuration writes.
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    import dsrd_pkg::*;

    // Configuration registers, reset to their documented defaults.
    logic        enable_reg;
    logic [15:0] dead_zone_reg;
    logic [9:0]  move_curve_reg;
    logic [9:0]  look_curve_reg;
    logic        invert_look_reg;
    logic        southpaw_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg      <= 1'b1;
            dead_zone_reg   <= 16'd11796;
            move_curve_reg  <= 10'd256;
            look_curve_reg  <= 10'd346;
            invert_look_reg <= 1'b0;
            southpaw_reg    <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_ENABLE:      enable_reg      <= cfg_data[0];
                CFG_DEAD_ZONE:   dead_zone_reg   <= cfg_data;
                CFG_MOVE_CURVE:  move_curve_reg  <= cfg_data[9:0];
                CFG_LOOK_CURVE:  look_curve_reg  <= cfg_data[9:0];
                CFG_INVERT_LOOK: invert_look_reg <= cfg_data[0];
                CFG_SOUTHPAW:    southpaw_reg    <= cfg_data[0];
                default:         ;
            endcase
        end
    end

    // Out-of-range settings are clamped where they are used.
    function automatic logic [9:0] clamp_curve(input logic [9:0] c);
        logic [9:0] v;
        v = c;
        if (c < CURVE_MIN)
        begin
            v = CURVE_MIN;
        end
        else if (c > CURVE_MAX)
        begin
            v = CURVE_MAX;
        end
        return v;
    endfunction

    logic [15:0] dz_clamped;
    stick_cfg_t  move_cfg, look_cfg;

    assign dz_clamped = (dead_zone_reg > DZ_MAX) ? DZ_MAX : dead_zone_reg;
    assign move_cfg   = '{dz: dz_clamped, curve: clamp_curve(move_curve_reg)};
    assign look_cfg   = '{dz: dz_clamped, curve: clamp_curve(look_curve_reg)};

    // The whole pipeline advances together whenever the output register can
    // take a new value.
    logic adv;
    logic m_valid_reg;

    assign adv      = !m_valid_reg || m_tready;
    assign s_tready = adv;

    // Southpaw decides which physical stick drives movement.
    logic [7:0] move_raw_x, move_raw_y, look_raw_x, look_raw_y;

    assign move_raw_x = southpaw_reg ? s_tdata[23:16] : s_tdata[7:0];
    assign move_raw_y = southpaw_reg ? s_tdata[31:24] : s_tdata[15:8];
    assign look_raw_x = southpaw_reg ? s_tdata[7:0]   : s_tdata[23:16];
    assign look_raw_y = southpaw_reg ? s_tdata[15:8]  : s_tdata[31:24];

    logic              mv_valid, lk_valid;
    logic signed [7:0] mv_x, mv_y, lk_x, lk_y;

    dsrd_stick u_move (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (adv),
        .in_valid (s_tvalid),
        .raw_x    (move_raw_x),
        .raw_y    (move_raw_y),
        .cfg      (move_cfg),
        .out_valid(mv_valid),
        .out_x    (mv_x),
        .out_y    (mv_y)
    );

    dsrd_stick u_look (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (adv),
        .in_valid (s_tvalid),
        .raw_x    (look_raw_x),
        .raw_y    (look_raw_y),
        .cfg      (look_cfg),
        .out_valid(lk_valid),
        .out_x    (lk_x),
        .out_y    (lk_y)
    );

    // Final sign conventions: move Y points forward, look Y inverts on request.
    // Disabling the axes forces every output to zero.
    logic signed [7:0] look_x_w, look_y_w, move_x_w, move_y_w;
    logic [31:0]       m_data_reg;

    assign look_x_w = enable_reg ? lk_x : 8'sd0;
    assign look_y_w = enable_reg ? (invert_look_reg ? -lk_y : lk_y) : 8'sd0;
    assign move_x_w = enable_reg ? mv_x : 8'sd0;
    assign move_y_w = enable_reg ? -mv_y : 8'sd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            m_valid_reg <= mv_valid && lk_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            m_data_reg <= {move_y_w, move_x_w, look_y_w, look_x_w};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

### sv/dsrd_checker.sv
// ----------------------------------------------------------------------------
// Dual stick radial dead zone: port checker
// Watches the top-level ports for stream behaviour and output range.
// ----------------------------------------------------------------------------
`include "dual_stick_radial_deadzone_defines.svh"

module dsrd_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata
);

    logic axis_ok;

    assign axis_ok = m_tdata[7:0] != 8'h80 && m_tdata[15:8] != 8'h80
                     && m_tdata[23:16] != 8'h80 && m_tdata[31:24] != 8'h80;

    // A stalled result stays put.
    `DSRD_ASSERT(a_out_hold, clk, rst_n, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))

    // A stalled output stops the intake as well.
    `DSRD_ASSERT(a_stall_input, clk, rst_n, m_tvalid && !m_tready |-> !s_tready)

    // The intake only closes when a result is waiting.
    `DSRD_ASSERT_MSG(a_ready_cause, clk, rst_n, !s_tready |-> m_tvalid, "input blocked with no result")

    // Every axis stays within plus or minus 127.
    `DSRD_ASSERT_MSG(a_axis_range, clk, rst_n, m_tvalid |-> axis_ok, "axis value out of range")

endmodule

bind dual_stick_radial_deadzone dsrd_checker u_dsrd_checker (.*);

### sim/dual_stick_radial_deadzone_chk.sv
// ----------------------------------------------------------------------------
// Dual stick radial dead zone: stream checker
// Watches the configuration, sample and axis channels, predicts the
// conditioned axes of every accepted sample and compares them in order.
// ----------------------------------------------------------------------------
module dual_stick_radial_deadzone_chk (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [31:0] s_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [31:0] m_tdata,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data,
    output int          fail_count,
    output int          pending,
    output int          axes_seen
);

    import dsrd_pkg::*;

    logic        en_q;
    logic [15:0] dz_q;
    logic [9:0]  move_curve_q;
    logic [9:0]  look_curve_q;
    logic        invert_q;
    logic        southpaw_q;

    logic [31:0] axes_due[$];

    function automatic longint unsigned root64(input longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'h1 << 62;
        while (b > v)
            b >>= 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v = v - r - b;
                r = (r >> 1) + b;
            end
            else
            begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic longint raw_to_q15(input logic [7:0] raw);
        longint c;
        c = longint'(raw) - 128;
        if (c < 0)
            return c * 256;
        return (c * 32768) / 127;
    endfunction

    function automatic longint unsigned shape_len(input longint unsigned a,
                                                   input logic [9:0] curve);
        longint unsigned r;
        longint unsigned s;
        int unsigned     e;
        e = curve;
        if (e < 256)
            e = 256;
        if (e > 768)
            e = 768;
        if (e == 256 || a == 0)
            return a;
        r = 65536;
        s = a;
        for (int i = 0; i < (e >> 8); i++)
            r = (r * a) >> 16;
        for (int i = 1; i <= 8; i++)
        begin
            s = root64(s << 16);
            if (((e & 255) >> (8 - i)) & 1)
                r = (r * s) >> 16;
        end
        return r;
    endfunction

    function automatic logic [7:0] rescale_axis(input longint a, input longint unsigned adj,
                                                input longint unsigned len);
        longint unsigned mag;
        longint unsigned q;
        longint          v;
        mag = (a < 0) ? -a : a;
        q = (mag * 2 * adj * 127) / (len * 65536);
        if (q > 127)
            q = 127;
        v = (a < 0) ? -longint'(q) : longint'(q);
        return v[7:0];
    endfunction

    // Returns {y, x} of one stick, each as an 8-bit two's complement value.
    function automatic logic [15:0] stick_axes(input logic [7:0] rx, input logic [7:0] ry,
                                               input logic [9:0] curve);
        longint          x;
        longint          y;
        longint unsigned dz;
        longint unsigned len;
        longint unsigned nl;
        longint unsigned adj;
        x = raw_to_q15(rx);
        y = raw_to_q15(ry);
        dz = (dz_q > 16'd62259) ? 62259 : dz_q;
        len = root64(longint'(x * x + y * y) << 2);
        if (len == 0 || len <= dz)
            return 16'h0;
        nl = (len > 65536) ? 65536 : len;
        adj = ((nl - dz) << 16) / (65536 - dz);
        if (adj > 65536)
            adj = 65536;
        adj = shape_len(adj, curve);
        return {rescale_axis(y, adj, len), rescale_axis(x, adj, len)};
    endfunction

    function automatic logic [31:0] conditioned_axes(input logic [31:0] d);
        logic [15:0] mv;
        logic [15:0] lk;
        logic [7:0]  my;
        logic [7:0]  ly;
        if (!en_q)
            return 32'h0;
        if (southpaw_q)
        begin
            mv = stick_axes(d[23:16], d[31:24], move_curve_q);
            lk = stick_axes(d[7:0], d[15:8], look_curve_q);
        end
        else
        begin
            mv = stick_axes(d[7:0], d[15:8], move_curve_q);
            lk = stick_axes(d[23:16], d[31:24], look_curve_q);
        end
        my = -mv[15:8];
        ly = invert_q ? -lk[15:8] : lk[15:8];
        return {my, mv[7:0], ly, lk[7:0]};
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        logic [31:0] want;
        string       names[4];
        int          errs;
        if (!rst_n)
        begin
            en_q         <= 1'b1;
            dz_q         <= 16'd11796;
            move_curve_q <= 10'd256;
            look_curve_q <= 10'd346;
            invert_q     <= 1'b0;
            southpaw_q   <= 1'b0;
            fail_count   <= 0;
            pending      <= 0;
            axes_seen    <= 0;
        end
        else
        begin
            names = '{"look_x", "look_y", "move_x", "move_y"};
            errs = 0;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_ENABLE:      en_q         <= cfg_data[0];
                    CFG_DEAD_ZONE:   dz_q         <= cfg_data;
                    CFG_MOVE_CURVE:  move_curve_q <= cfg_data[9:0];
                    CFG_LOOK_CURVE:  look_curve_q <= cfg_data[9:0];
                    CFG_INVERT_LOOK: invert_q     <= cfg_data[0];
                    CFG_SOUTHPAW:    southpaw_q   <= cfg_data[0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
                axes_due.push_back(conditioned_axes(s_tdata));
            if (m_tvalid && m_tready)
            begin
                axes_seen <= axes_seen + 1;
                if (axes_due.size() == 0)
                begin
                    $display("%0t: unexpected axis transaction, expected none, got %h",
                             $time, m_tdata);
                    errs = 1;
                end
                else
                begin
                    want = axes_due.pop_front();
                    for (int f = 0; f < 4; f++)
                    begin
                        if (m_tdata[f*8 +: 8] !== want[f*8 +: 8])
                        begin
                            $display("%0t: %s mismatch, expected %0d, got %0d", $time,
                                     names[f], $signed(want[f*8 +: 8]),
                                     $signed(m_tdata[f*8 +: 8]));
                            errs++;
                        end
                    end
                end
                fail_count <= fail_count + errs;
            end
            pending <= axes_due.size();
        end
    end

endmodule

### sim/dual_stick_radial_deadzone_tb.sv
// ----------------------------------------------------------------------------
// Dual stick radial dead zone: testbench top
// Drives controller samples and register writes through several settings
// under varying back-pressure; the checker predicts and compares the axes.
// ----------------------------------------------------------------------------
module dual_stick_radial_deadzone_tb;

    import dsrd_pkg::*;

    // Indexes past the register list; writes to them must change nothing.
    localparam logic [2:0] CFG_SPARE_LO = 3'd6;
    localparam logic [2:0] CFG_SPARE_HI = 3'd7;

    // Pipeline depth of the block, plus a margin for draining.
    localparam int DRAIN_CYCLES = 120;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [15:0] cfg_data = '0;

    int fail_count;
    int pending;
    int axes_seen;
    int samples_sent = 0;

    // Idle percentages of each side; the receiver process reads its own.
    int send_idle_pct = 17;
    int recv_idle_pct = 66;
    // Set by the stimulus to ask the receiver for one long hold-off.
    bit hold_req = 1'b0;

    always #5 clk = ~clk;

    dual_stick_radial_deadzone i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    dual_stick_radial_deadzone_chk i_chk (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .fail_count (fail_count),
        .pending    (pending),
        .axes_seen  (axes_seen)
    );

    // The receiver. Ready changes only at rising edges. A hold-off request
    // keeps it low for a long, counted stretch so that the pipeline fills
    // and the slave side has to stall.
    initial
    begin
        int held;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                m_tready <= 1'b0;
                for (held = 0; held < 300; held++)
                    @(posedge clk);
                hold_req = 1'b0;
            end
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // One sample transaction. Ready is looked at in the middle of the cycle,
    // when it is settled, and the transfer takes place at the next edge.
    task automatic send_sample(input logic [31:0] d);
        bit done;
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= d;
        done = 1'b0;
        while (!done)
        begin
            @(negedge clk);
            done = s_tready;
            @(posedge clk);
        end
        samples_sent++;
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [15:0] d);
        bit done;
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= d;
        done = 1'b0;
        while (!done)
        begin
            @(negedge clk);
            done = cfg_ready;
            @(posedge clk);
        end
        cfg_valid <= 1'b0;
    endtask

    // Registers may only change with nothing in flight. A clock edge passes first
    // so that the in-flight count includes a sample accepted just now.
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // One full setting. Spare bits above each register's width are random,
    // since the block must ignore them.
    task automatic apply_setting(input bit en, input logic [15:0] dz,
                                 input logic [9:0] mc, input logic [9:0] lc,
                                 input bit inv, input bit sp);
        wait_idle();
        write_reg(CFG_ENABLE, {15'($urandom_range(32767)), en});
        write_reg(CFG_DEAD_ZONE, dz);
        write_reg(CFG_MOVE_CURVE, {6'($urandom), mc});
        write_reg(CFG_LOOK_CURVE, {6'($urandom), lc});
        write_reg(CFG_INVERT_LOOK, {15'($urandom_range(32767)), inv});
        write_reg(CFG_SOUTHPAW, {15'($urandom_range(32767)), sp});
    endtask

    function automatic logic [7:0] stick_byte();
        int pick;
        pick = $urandom_range(99);
        if (pick < 20)
            return 8'(128 + $urandom_range(40) - 20);
        if (pick < 40)
            return $urandom_range(1) ? 8'hff : 8'h00;
        return 8'($urandom);
    endfunction

    function automatic logic [15:0] rand_dz();
        case ($urandom_range(3))
            0: return 16'($urandom_range(6000));
            1: return 16'($urandom_range(62259));
            2: return 16'($urandom_range(65535, 62000));
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [9:0] rand_curve();
        case ($urandom_range(3))
            0: return 10'($urandom_range(768, 256));
            1: return 10'(256 * $urandom_range(3, 1));
            default: return 10'($urandom);
        endcase
    endfunction

    initial
    begin
        logic [7:0] corner[5];
        int         phase;
        corner = '{8'h00, 8'h7f, 8'h80, 8'h81, 8'hff};

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part at the reset settings: centre, the extremes of every
        // byte, a sample just off centre and the full diagonals.
        send_sample({4{8'h80}});
        for (int i = 0; i < 5; i++)
            send_sample({corner[i], corner[4 - i], corner[(i + 2) % 5], corner[i]});
        send_sample({8'hff, 8'hff, 8'h00, 8'h00});
        send_sample({8'h00, 8'h00, 8'hff, 8'hff});
        send_sample({8'h81, 8'h80, 8'h80, 8'h7f});

        // Dead zone off, linear curves: the smallest deflection gets through.
        apply_setting(1'b1, 16'd0, 10'd256, 10'd256, 1'b0, 1'b0);
        for (int i = 0; i < 5; i++)
            send_sample({corner[i], corner[(i + 1) % 5], corner[(i + 3) % 5], corner[4 - i]});
        // Largest legal dead zone and steepest curves, inverted and swapped.
        apply_setting(1'b1, 16'd62259, 10'd768, 10'd768, 1'b1, 1'b1);
        send_sample({8'hff, 8'h00, 8'h00, 8'hff});
        send_sample({8'h80, 8'h80, 8'h90, 8'h70});
        // Dead zone above the limit and curves outside their range get clamped.
        apply_setting(1'b1, 16'hffff, 10'd0, 10'h3ff, 1'b0, 1'b1);
        send_sample({8'h00, 8'hff, 8'hff, 8'h00});
        send_sample({8'hff, 8'hff, 8'h00, 8'h00});
        // Disabled: every axis must read zero.
        apply_setting(1'b0, 16'd11796, 10'd346, 10'd300, 1'b1, 1'b0);
        send_sample({8'hff, 8'h00, 8'h00, 8'hff});
        send_sample({8'h10, 8'he0, 8'h33, 8'hcc});
        // Writes beyond the register list must be ignored.
        wait_idle();
        write_reg(CFG_SPARE_LO, 16'($urandom));
        write_reg(CFG_SPARE_HI, 16'($urandom));
        write_reg(CFG_ENABLE, 16'h0001);
        write_reg(CFG_SPARE_LO, 16'hffff);
        write_reg(CFG_SPARE_HI, 16'h0000);
        send_sample({8'h00, 8'h00, 8'hff, 8'hff});

        // Random part: nine settings of about a hundred samples each, the
        // idle pattern changing every three.
        for (phase = 0; phase < 9; phase++)
        begin
            if (phase < 3)
            begin
                send_idle_pct = 17;
                recv_idle_pct = 66;
            end
            else if (phase < 6)
            begin
                send_idle_pct = 66;
                recv_idle_pct = 17;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            if (phase == 8)
                apply_setting(1'b1, 16'd11796, 10'd256, 10'd346, 1'b0, 1'b0);
            else
                apply_setting($urandom_range(5) != 0, rand_dz(), rand_curve(),
                              rand_curve(), 1'($urandom), 1'($urandom));
            for (int n = 0; n < 103; n++)
            begin
                if (n == 10 && (phase == 0 || phase == 7))
                    hold_req = 1'b1;
                send_sample({stick_byte(), stick_byte(), stick_byte(), stick_byte()});
            end
        end

        s_tvalid <= 1'b0;
        wait_idle();
        $display("Sent %0d controller samples over thirteen settings and checked %0d axis sets.",
                 samples_sent, axes_seen);
        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial
    begin
        #20000000;
        $display("Timeout waiting for the axis stream to drain.");
        $display("Some tests failed");
        $finish;
    end

endmodule
